// ----- sv/twcf_pkg.sv -----
// Shared types and constants for the texture window CLUT fetch block.
// No dependencies; imported by twcf_ctrl, twcf_dp and the top level (twcf_ram does not use it).
`timescale 1ns / 1ps
`default_nettype none

package twcf_pkg;

  // Video memory geometry
  localparam int unsigned MEM_COLUMNS_DEF = 1024;
  localparam int unsigned MEM_ROWS_DEF    = 512;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CONTROL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LOCATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET_Y  = 3'd5;

  localparam int unsigned PAGE_W = 9;
  localparam int unsigned PAL_W  = 15;
  localparam int unsigned WIN_W  = 5;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Colour modes
  localparam logic [1:0] MODE_4BIT = 2'd0;
  localparam logic [1:0] MODE_8BIT = 2'd1;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned TEX_W  = 8;

  // Controller -> datapath
  typedef struct packed {
    logic write;     // store one word
    logic fetch;     // read texel word at the page position
    logic clut;      // read palette entry from the fetched index
    logic load_out;  // capture RAM read data into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic indexed;   // colour mode goes through the palette
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/twcf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module twcf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/twcf_ctrl.sv -----
// Sequencer for the texel fetch: accept, texel read, optional palette read.
// Depends on twcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twcf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 command_i,
  output logic                      in_stall_o,
  input  wire twcf_pkg::dp_status_t status_i,
  output twcf_pkg::ctrl_cmd_t       cmd_o
);
  import twcf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TEXEL = 2'd1;  // texel word arrives from RAM
  localparam logic [1:0] ST_CLUT  = 2'd2;  // palette entry arrives from RAM

  logic [1:0] state_q, state_d;
  logic       done;
  logic       ready;
  logic       accept;

  // result goes to the output register this cycle
  assign done = ((state_q == ST_TEXEL) && !status_i.indexed && status_i.out_free) ||
                ((state_q == ST_CLUT) && status_i.out_free);

  assign ready      = (state_q == ST_IDLE) || done;
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  assign cmd_o.write    = accept && (command_i == CMD_WRITE);
  assign cmd_o.fetch    = accept && (command_i == CMD_SAMPLE);
  assign cmd_o.clut     = (state_q == ST_TEXEL) && status_i.indexed;
  assign cmd_o.load_out = done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_TEXEL: begin
        if (status_i.indexed) begin
          state_d = ST_CLUT;
        end else if (done) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLUT: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.fetch) begin
      state_d = ST_TEXEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/twcf_dp.sv -----
// Datapath: config registers, window and page address math, video RAM,
// index extraction and output register. Depends on twcf_pkg and twcf_ram.
`timescale 1ns / 1ps
`default_nettype none

module twcf_dp #(
  parameter int unsigned MEM_COLUMNS = twcf_pkg::MEM_COLUMNS_DEF,
  parameter int unsigned MEM_ROWS    = twcf_pkg::MEM_ROWS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [twcf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [twcf_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [twcf_pkg::TEX_W-1:0]            tex_u_i,
  input  wire logic [twcf_pkg::TEX_W-1:0]            tex_v_i,
  input  wire logic [$clog2(MEM_COLUMNS)-1:0]        mem_x_i,
  input  wire logic [$clog2(MEM_ROWS)-1:0]           mem_y_i,
  input  wire logic [twcf_pkg::WORD_W-1:0]           write_word_i,
  input  wire twcf_pkg::ctrl_cmd_t                   cmd_i,
  output twcf_pkg::dp_status_t                       status_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [twcf_pkg::WORD_W-1:0]                texel_word_o
);
  import twcf_pkg::*;

  localparam int unsigned ColW  = $clog2(MEM_COLUMNS);
  localparam int unsigned RowW  = $clog2(MEM_ROWS);
  localparam int unsigned AddrW = ColW + RowW;

  // configuration
  logic [PAGE_W-1:0] page_q;
  logic [PAL_W-1:0]  pal_q;
  logic [WIN_W-1:0]  mask_x_q, mask_y_q, off_x_q, off_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q   <= '0;
      pal_q    <= '0;
      mask_x_q <= '0;
      mask_y_q <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PAGE_CONTROL:     page_q   <= cfg_data_i[PAGE_W-1:0];
        CFG_PALETTE_LOCATION: pal_q    <= cfg_data_i[PAL_W-1:0];
        CFG_WINDOW_MASK_X:    mask_x_q <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_MASK_Y:    mask_y_q <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_OFFSET_X:  off_x_q  <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_OFFSET_Y:  off_y_q  <= cfg_data_i[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [1:0] mode;
  assign mode             = page_q[8:7];
  assign status_o.indexed = (mode == MODE_4BIT) || (mode == MODE_8BIT);

  // texture window: masked bits replaced by offset bits (8-texel units)
  logic [TEX_W-1:0] win_u, win_v;
  assign win_u = (tex_u_i & ~{mask_x_q, 3'b000}) | {off_x_q & mask_x_q, 3'b000};
  assign win_v = (tex_v_i & ~{mask_y_q, 3'b000}) | {off_y_q & mask_y_q, 3'b000};

  // texel word position inside the page; columns wrap
  logic [ColW-1:0] base_col, u_col, tex_col;
  logic [RowW-1:0] tex_row;

  assign base_col = ColW'({page_q[3:0], 6'b000000});

  always_comb begin
    case (mode)
      MODE_4BIT: u_col = ColW'(win_u[7:2]);
      MODE_8BIT: u_col = ColW'(win_u[7:1]);
      default:   u_col = ColW'(win_u);
    endcase
  end

  assign tex_col = base_col + u_col;
  assign tex_row = RowW'({page_q[4], win_v});

  // sub-word texel select, kept for the cycle the texel word arrives
  logic [1:0] u_sel_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      u_sel_q <= win_u[1:0];
    end
  end

  // palette lookup from the fetched word
  logic [WORD_W-1:0] rdata;
  logic [7:0]        idx;
  logic [3:0]        nibble;
  logic [ColW-1:0]   pal_col;
  logic [RowW-1:0]   pal_row;

  always_comb begin
    case (u_sel_q)
      2'd0:    nibble = rdata[3:0];
      2'd1:    nibble = rdata[7:4];
      2'd2:    nibble = rdata[11:8];
      default: nibble = rdata[15:12];
    endcase
  end

  assign idx     = (mode == MODE_4BIT) ? {4'b0000, nibble}
                                       : (u_sel_q[0] ? rdata[15:8] : rdata[7:0]);
  assign pal_col = ColW'({pal_q[5:0], 4'b0000}) + ColW'(idx);
  assign pal_row = RowW'(pal_q[14:6]);

  // video memory
  logic [AddrW-1:0] raddr, waddr;
  assign raddr = cmd_i.fetch ? {tex_row, tex_col} : {pal_row, pal_col};
  assign waddr = {mem_y_i, mem_x_i};

  twcf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_COLUMNS * MEM_ROWS)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (waddr),
    .wdata_i (write_word_i),
    .re_i    (cmd_i.fetch || cmd_i.clut),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] texel_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_d       = cmd_i.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      texel_q <= rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign texel_word_o = texel_q;

endmodule

`default_nettype wire

// ----- sv/texture_window_clut_fetch.sv -----
// Top level of the texture window CLUT fetch block: controller plus datapath.
// Depends on twcf_pkg, twcf_ctrl, twcf_dp and twcf_ram.
`timescale 1ns / 1ps
`default_nettype none

// Texel fetch unit over a 1024 x 512 video memory of 16-bit words. An input
// item with command 0 stores write_word at (mem_x, mem_y) and gives no result;
// an item with command 1 applies the texture window to (tex_u, tex_v), places
// the texel in the texture page and returns one texel_word. Colour modes 0 and
// 1 read a packed 4-bit or 8-bit index and then the palette entry; modes 2 and
// 3 return the page word directly. All columns wrap at 1024 and rows at 512.
// A write never holds the input. A sample holds it while the output register
// is full and stalled; an indexed one also holds it for its palette read, as
// the video RAM has a single read port and that read needs the index word.
// A finished result sits in an output register, so the next item is taken
// while it waits. Memory content is undefined until written; no clearing pass.
// The user must write configuration registers only while idle (not enforced).
module texture_window_clut_fetch #(
  parameter int unsigned MEM_COLUMNS = twcf_pkg::MEM_COLUMNS_DEF,
  parameter int unsigned MEM_ROWS    = twcf_pkg::MEM_ROWS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [twcf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [twcf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               command_i,
  input  wire logic [twcf_pkg::TEX_W-1:0]         tex_u_i,
  input  wire logic [twcf_pkg::TEX_W-1:0]         tex_v_i,
  input  wire logic [$clog2(MEM_COLUMNS)-1:0]     mem_x_i,
  input  wire logic [$clog2(MEM_ROWS)-1:0]        mem_y_i,
  input  wire logic [twcf_pkg::WORD_W-1:0]        write_word_i,
  // result items
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [twcf_pkg::WORD_W-1:0]             texel_word_o
);
  import twcf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing: when to read, when a result is ready
  twcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // address math, video RAM and output register
  twcf_dp #(
    .MEM_COLUMNS (MEM_COLUMNS),
    .MEM_ROWS    (MEM_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .mem_x_i      (mem_x_i),
    .mem_y_i      (mem_y_i),
    .write_word_i (write_word_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .texel_word_o (texel_word_o)
  );

  // The RAM has one write and one read per cycle, but the controller never
  // needs both at once.
  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.write && (cmd.fetch || cmd.clut)))
    else $error("video RAM write and read issued in the same cycle");

  // A palette read only ever follows the texel read of the same item.
  a_clut_after_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clut |-> $past(cmd.fetch))
    else $error("palette read without a preceding texel read");

  // A result never lands on a waiting one.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && out_valid_o) |-> !out_stall_i)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ----- tb/sv/tb_texture_window_clut_fetch.sv -----
// Self-checking bench for texture_window_clut_fetch: a directed table, then random write and
// sample traffic, each result checked against the table's value or a behavioral texel predictor.
// Depends on twcf_pkg and the texture_window_clut_fetch RTL.
`timescale 1ns / 1ps

module tb_texture_window_clut_fetch;
  import twcf_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 210;   // items per random phase, prep writes included
  localparam int unsigned HOLD_PHASE   = 4;     // phase with the long receiver hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;     // > write latency, before config writes
  localparam int unsigned QUIET_LIMIT  = 3000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HOT_DEPTH    = 32;
  localparam int unsigned DIR_ROWS     = 34;

  typedef enum bit [1:0] {ROW_CFG, ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum bit [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // one input item, one field per port
  typedef struct packed {
    logic      cmd;
    bit [7:0]  u;
    bit [7:0]  v;
    bit [9:0]  x;
    bit [8:0]  y;
    bit [15:0] data;
  } tex_item_t;

  // shadow of the configuration registers
  typedef struct packed {
    bit [8:0]  page;
    bit [14:0] palette;
    bit [4:0]  mask_x;
    bit [4:0]  mask_y;
    bit [4:0]  off_x;
    bit [4:0]  off_y;
  } tex_regs_t;

  // directed row: a register write or an item; want is used when check is set.
  // reg_idx only matters on ROW_CFG rows.
  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    bit [15:0]                data;
    bit [7:0]                 u;
    bit [7:0]                 v;
    bit [9:0]                 x;
    bit [8:0]                 y;
    bit                       check;
    bit [15:0]                want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = CFG_PAGE_CONTROL;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  command_i    = CMD_WRITE;
  logic [7:0]            tex_u_i      = '0;
  logic [7:0]            tex_v_i      = '0;
  logic [9:0]            mem_x_i      = '0;
  logic [8:0]            mem_y_i      = '0;
  logic [15:0]           write_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [15:0]           texel_word_o;

  texture_window_clut_fetch dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .tex_u_i      (tex_u_i),
    .tex_v_i      (tex_v_i),
    .mem_x_i      (mem_x_i),
    .mem_y_i      (mem_y_i),
    .write_word_i (write_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .texel_word_o (texel_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow and the words written so far. Only entries
  // present in vram_img are ever read by a sample, since memory has no reset.
  // Key is {row, col}.
  // ---------------------------------------------------------------------------
  tex_regs_t   tex_regs = '0;
  bit [15:0]   vram_img [bit [18:0]];
  bit [18:0]   hot_q [$];            // recently read words, targets for overwrites
  bit [15:0]   texel_expect_q [$];   // predicted texel words, oldest first
  bit [15:0]   texel_want;
  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  // handshake pacing, set by the stimulus process
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          long_hold_req  = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  // Directed part. Reset config is mode 0, page 0, palette at (0,0).
  dir_row_t walk_rows [DIR_ROWS] = '{
    // 4-bit mode: index word FC21 at (0,1), palette entries 1, 2, 12, 15 on row 0;
    // tex fields of a write are ignored
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'hFC21, 8'd255, 8'd255, 10'd0,    9'd1,   1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h0001, 8'd0,   8'd0,   10'd1,    9'd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h0002, 8'd0,   8'd0,   10'd2,    9'd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'hFFFF, 8'd0,   8'd0,   10'd12,   9'd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h8000, 8'd0,   8'd0,   10'd15,   9'd0,   1'b0, 16'h0000},
    // memory fields of a sample are ignored
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'hFFFF, 8'd0,   8'd1,   10'd1023, 9'd511, 1'b1, 16'h0001},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd1,   8'd1,   10'd0,    9'd0,   1'b1, 16'h0002},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd2,   8'd1,   10'd0,    9'd0,   1'b1, 16'hFFFF},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd3,   8'd1,   10'd0,    9'd0,   1'b1, 16'h8000},
    // 8-bit mode with the unused page bits set; palette at x 1008, row 511 so the
    // index 0x21 wraps to column 17 and 0xFC to column 236
    '{ROW_CFG,    CFG_PAGE_CONTROL,     16'h00E0, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_PALETTE_LOCATION, 16'h7FFF, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h1234, 8'd0,   8'd0,   10'd17,   9'd511, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'hABCD, 8'd0,   8'd0,   10'd236,  9'd511, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd0,   8'd1,   10'd0,    9'd0,   1'b1, 16'h1234},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd1,   8'd1,   10'd0,    9'd0,   1'b1, 16'hABCD},
    // direct mode 2, page x 960 and y 256: column 960+255 wraps to 191, 960+64 to 0
    '{ROW_CFG,    CFG_PAGE_CONTROL, 16'h011F, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h5A5A, 8'd0,   8'd0,   10'd191,  9'd511, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h0F0F, 8'd0,   8'd0,   10'd0,    9'd256, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h0000, 8'd0,   8'd0,   10'd1023, 9'd511, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd255, 8'd255, 10'd0,    9'd0,   1'b1, 16'h5A5A},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd64,  8'd0,   10'd0,    9'd0,   1'b1, 16'h0F0F},
    // mode 3 reads the same direct word, every page bit set
    '{ROW_CFG,    CFG_PAGE_CONTROL, 16'h01FF, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd63,  8'd255, 10'd0,    9'd0,   1'b1, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd255, 8'd255, 10'd0,    9'd0,   1'b1, 16'h5A5A},
    // full window: u and v become 248 + low three bits
    '{ROW_CFG,    CFG_WINDOW_MASK_X,   16'h001F, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_WINDOW_MASK_Y,   16'h001F, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_WINDOW_OFFSET_X, 16'h001F, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_WINDOW_OFFSET_Y, 16'h001F, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_WRITE,  CFG_PAGE_CONTROL, 16'h7E7E, 8'd0,   8'd0,   10'd184,  9'd504, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd0,   8'd0,   10'd0,    9'd0,   1'b1, 16'h7E7E},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd7,   8'd7,   10'd0,    9'd0,   1'b1, 16'h5A5A},
    // offset without mask has no effect
    '{ROW_CFG,    CFG_WINDOW_MASK_X,   16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_CFG,    CFG_WINDOW_MASK_Y,   16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 1'b0, 16'h0000},
    '{ROW_SAMPLE, CFG_PAGE_CONTROL, 16'h0000, 8'd255, 8'd255, 10'd0,    9'd0,   1'b1, 16'h5A5A}
  };

  // ---------------------------------------------------------------------------
  // Texel predictor
  // ---------------------------------------------------------------------------
  // window: masked bits (mask*8) are replaced by the offset bits
  function automatic bit [7:0] apply_window(bit [7:0] raw, bit [4:0] mask, bit [4:0] offs);
    return (raw & ~{mask, 3'b000}) | {mask & offs, 3'b000};
  endfunction

  function automatic bit is_indexed();
    return tex_regs.page[8:7] == MODE_4BIT || tex_regs.page[8:7] == MODE_8BIT;
  endfunction

  // page word holding the texel (or its packed index); 10/9-bit math wraps
  function automatic bit [18:0] page_word_addr(bit [7:0] u, bit [7:0] v);
    bit [9:0] col;
    bit [8:0] row;
    row = {tex_regs.page[4], 8'h00} + {1'b0, v};
    case (tex_regs.page[8:7])
      MODE_4BIT: col = {tex_regs.page[3:0], 6'd0} + {4'd0, u[7:2]};
      MODE_8BIT: col = {tex_regs.page[3:0], 6'd0} + {3'd0, u[7:1]};
      default:   col = {tex_regs.page[3:0], 6'd0} + {2'd0, u};
    endcase
    return {row, col};
  endfunction

  // palette entry selected by the index packed in index_word
  function automatic bit [18:0] clut_entry_addr(bit [15:0] index_word, bit [7:0] u);
    bit [7:0] idx;
    bit [9:0] col;
    if (tex_regs.page[8:7] == MODE_4BIT) begin
      idx = {4'd0, index_word[u[1:0]*4 +: 4]};
    end else begin
      idx = u[0] ? index_word[15:8] : index_word[7:0];
    end
    col = {tex_regs.palette[5:0], 4'd0} + {2'd0, idx};
    return {tex_regs.palette[14:6], col};
  endfunction

  function automatic bit [15:0] predict_texel(bit [7:0] raw_u, bit [7:0] raw_v);
    bit [7:0]  u;
    bit [7:0]  v;
    bit [15:0] texel;
    u = apply_window(raw_u, tex_regs.mask_x, tex_regs.off_x);
    v = apply_window(raw_v, tex_regs.mask_y, tex_regs.off_y);
    texel = vram_img[page_word_addr(u, v)];
    if (is_indexed()) texel = vram_img[clut_entry_addr(texel, u)];
    return texel;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic tex_item_t rand_item(logic cmd);
    tex_item_t it;
    it.cmd  = cmd;
    it.u    = 8'($urandom_range(255));
    it.v    = 8'($urandom_range(255));
    it.x    = 10'($urandom_range(1023));
    it.y    = 9'($urandom_range(511));
    it.data = 16'($urandom_range(65535));
    return it;
  endfunction

  // edges of the u/v range are favored, the rest is uniform
  function automatic bit [7:0] pick_coord();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return 8'($urandom_range(3));
    if (r < 4) return 8'(255 - $urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // register value: zero, top or anything in between
  function automatic int unsigned pick_field(int unsigned top);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(top);
  endfunction

  // Offers one item after an optional random gap, waits for the handshake and
  // updates the predictor. A sample takes the literal want when fixed is set.
  task automatic send_item(input tex_item_t it, input bit fixed, input bit [15:0] want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= it.cmd;
    tex_u_i      <= it.u;
    tex_v_i      <= it.v;
    mem_x_i      <= it.x;
    mem_y_i      <= it.y;
    write_word_i <= it.data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.cmd == CMD_WRITE) begin
      vram_img[{it.y, it.x}] = it.data;
    end else begin
      texel_expect_q = {texel_expect_q, (fixed ? want : predict_texel(it.u, it.v))};
    end
    items_sent++;
  endtask

  // random word into one memory location
  task automatic store_word(input bit [18:0] addr);
    tex_item_t it;
    it   = rand_item(CMD_WRITE);
    it.x = addr[9:0];
    it.y = addr[18:10];
    send_item(it, 1'b0, 16'h0000);
  endtask

  // stop offering, collect every pending texel, then let trailing writes retire
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (texel_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write; the caller lowers cfg_we_i after the last of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_PAGE_CONTROL:     tex_regs.page    = value[8:0];
      CFG_PALETTE_LOCATION: tex_regs.palette = value[14:0];
      CFG_WINDOW_MASK_X:    tex_regs.mask_x  = value[4:0];
      CFG_WINDOW_MASK_Y:    tex_regs.mask_y  = value[4:0];
      CFG_WINDOW_OFFSET_X:  tex_regs.off_x   = value[4:0];
      CFG_WINDOW_OFFSET_Y:  tex_regs.off_y   = value[4:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // result checker: each accepted texel against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (texel_expect_q.size() == 0) begin
        note_failure($sformatf("texel %h with no item pending", texel_word_o));
      end else begin
        texel_want = texel_expect_q.pop_front();
        if (texel_word_o !== texel_want) begin
          note_failure($sformatf("texel_word expected %h actual %h", texel_want, texel_word_o));
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    int unsigned first_item;
    int unsigned pick;
    bit          cfg_open;
    tex_item_t   it;
    tex_regs_t   regs;
    bit [7:0]    u;
    bit [7:0]    v;
    bit [7:0]    wu;
    bit [7:0]    wv;
    bit [18:0]   page_at;
    bit [18:0]   clut_at;

    cfg_open = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; register writes only once the block has drained
    for (row = 0; row < DIR_ROWS; row++) begin
      if (walk_rows[row].kind == ROW_CFG) begin
        if (!cfg_open) wait_idle();
        write_reg(walk_rows[row].reg_idx, walk_rows[row].data[CFG_DATA_W-1:0]);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we_i <= 1'b0;
        cfg_open = 1'b0;
        it.cmd  = (walk_rows[row].kind == ROW_SAMPLE) ? CMD_SAMPLE : CMD_WRITE;
        it.u    = walk_rows[row].u;
        it.v    = walk_rows[row].v;
        it.x    = walk_rows[row].x;
        it.y    = walk_rows[row].y;
        it.data = walk_rows[row].data;
        send_item(it, walk_rows[row].check, walk_rows[row].want);
      end
    end

    // random phases: first all-zero registers, last all-ones, others mixed
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        regs = '0;
      end else if (phase == PHASES - 1) begin
        regs = '1;
      end else begin
        regs.page    = 9'(pick_field(511));
        regs.palette = 15'(pick_field(32767));
        regs.mask_x  = 5'(pick_field(31));
        regs.mask_y  = 5'(pick_field(31));
        regs.off_x   = 5'(pick_field(31));
        regs.off_y   = 5'(pick_field(31));
      end
      wait_idle();
      write_reg(CFG_PAGE_CONTROL,     15'(regs.page));
      write_reg(CFG_PALETTE_LOCATION, regs.palette);
      write_reg(CFG_WINDOW_MASK_X,    15'(regs.mask_x));
      write_reg(CFG_WINDOW_MASK_Y,    15'(regs.mask_y));
      write_reg(CFG_WINDOW_OFFSET_X,  15'(regs.off_x));
      write_reg(CFG_WINDOW_OFFSET_Y,  15'(regs.off_y));
      cfg_we_i <= 1'b0;

      case (idle_mode_e'(phase % 4))
        IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        IDLE_SENDER:   begin src_idle_pct = 67; sink_stall_pct = 0;  end
        IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default:       begin src_idle_pct = 8;  sink_stall_pct = 8;  end
      endcase
      // sender keeps offering at full rate while the receiver holds off
      if (phase == HOLD_PHASE) long_hold_req = 1'b1;

      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          // stray write anywhere in memory
          send_item(rand_item(CMD_WRITE), 1'b0, 16'h0000);
        end else if (pick < 22 && hot_q.size() != 0) begin
          // overwrite a word that samples have read
          store_word(hot_q[$urandom_range(hot_q.size() - 1)]);
        end else begin
          // well-formed sample: fill whatever it reads first, then sample
          u  = pick_coord();
          v  = pick_coord();
          wu = apply_window(u, tex_regs.mask_x, tex_regs.off_x);
          wv = apply_window(v, tex_regs.mask_y, tex_regs.off_y);
          page_at = page_word_addr(wu, wv);
          if (!vram_img.exists(page_at)) store_word(page_at);
          hot_q = {hot_q, page_at};
          if (is_indexed()) begin
            clut_at = clut_entry_addr(vram_img[page_at], wu);
            if (!vram_img.exists(clut_at)) store_word(clut_at);
            hot_q = {hot_q, clut_at};
          end
          while (hot_q.size() > HOT_DEPTH) void'(hot_q.pop_front());
          it   = rand_item(CMD_SAMPLE);
          it.u = u;
          it.v = v;
          send_item(it, 1'b0, 16'h0000);
        end
      end
    end

    wait_idle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
